// ===== src/text_console_writer_defines.svh =====
// Assertion macros for the text console writer.
// Depends on clk and rst in the scope of use.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`define TCW_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcw assertion failed");

`define TCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcw assertion failed");

`endif

// ===== src/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
// No dependencies.
package tcw_pkg;

  localparam int ROWS    = 25;
  localparam int COLUMNS = 80;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;

  localparam logic [1:0] CMD_PRINT    = 2'd0;
  localparam logic [1:0] CMD_PRINT_AT = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;
  localparam logic [1:0] CMD_READ     = 2'd3;

  localparam logic [7:0] CH_NEWLINE  = 8'h0A;
  localparam logic [7:0] CH_FORMFEED = 8'h0C;
  localparam logic [7:0] CH_RETURN   = 8'h0D;

  localparam logic [7:0] RESET_BLANK_ATTR = 8'd7;

  typedef enum logic [2:0] {
    K_WRITE, K_WRITE_CUR, K_NEWLINE, K_FORMFEED, K_RETURN, K_CLEAR, K_READ, K_IGNORE
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [7:0]       ch;
    logic [7:0]       attr;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } op_t;

endpackage

// ===== src/tcw_front.sv =====
// Front end: accepts commands and classifies them into console operations.
// Depends on tcw_pkg.
module tcw_front (
  input  logic                   start,
  input  logic                   q_full,
  input  logic                   init_busy,
  input  logic [1:0]             cmd,
  input  logic [7:0]             char_code,
  input  logic [3:0]             ink_color,
  input  logic [3:0]             paper_color,
  input  logic [tcw_pkg::ROW_W-1:0] row,
  input  logic [tcw_pkg::COL_W-1:0] col,
  output logic                   busy,
  output logic                   push,
  output tcw_pkg::op_t           op
);
  import tcw_pkg::*;

  logic on_screen;

  assign on_screen = (row < ROW_W'(ROWS)) && (col < COL_W'(COLUMNS));
  assign busy = q_full || init_busy;
  assign push = start && !busy;

  always_comb begin
    op.ch   = char_code;
    op.attr = {paper_color, ink_color};
    op.row  = row;
    op.col  = col;
    op.kind = K_IGNORE;
    unique case (cmd)
      CMD_PRINT, CMD_PRINT_AT: begin
        if (cmd == CMD_PRINT_AT && !on_screen) op.kind = K_IGNORE;
        else if (char_code == CH_NEWLINE) op.kind = K_NEWLINE;
        else if (char_code == CH_FORMFEED) op.kind = K_FORMFEED;
        else if (char_code == CH_RETURN) op.kind = K_RETURN;
        else op.kind = (cmd == CMD_PRINT) ? K_WRITE_CUR : K_WRITE;
      end
      CMD_CLEAR: op.kind = K_CLEAR;
      CMD_READ: op.kind = on_screen ? K_READ : K_IGNORE;
      default: op.kind = K_IGNORE;
    endcase
  end

endmodule

// ===== src/tcw_queue.sv =====
// Two-word queue of decoded operations between front and back end.
// Depends on tcw_pkg.
module tcw_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  tcw_pkg::op_t push_op,
  input  logic         pop,
  output logic         full,
  output logic         empty,
  output tcw_pkg::op_t head
);
  import tcw_pkg::*;

  op_t        slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== src/tcw_back.sv =====
// Back end: cell store, cursor, scroll and fill sequencer, result register.
// Depends on tcw_pkg.
module tcw_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      empty,
  input  tcw_pkg::op_t              head,
  input  logic [7:0]                blank_attr,
  output logic                      pop,
  output logic                      init_busy,
  output logic                      done,
  output logic [tcw_pkg::ROW_W-1:0] cursor_row,
  output logic [tcw_pkg::COL_W-1:0] cursor_col,
  output logic [7:0]                cell_char,
  output logic [7:0]                cell_attr,
  output logic                      ignored
);
  import tcw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_SCROLL = 4'b0100,
    S_FILL   = 4'b1000
  } state_t;

  localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(CELLS - 1);
  localparam logic [CNT_W-1:0]  COLS_C = CNT_W'(COLUMNS);
  localparam logic [CNT_W-1:0]  MOVE_C = CNT_W'(CELLS - COLUMNS);

  logic [15:0]       mem [CELLS];
  logic [15:0]       rdata;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [15:0]       wdata;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [7:0]       fill_attr, fill_attr_next;
  logic             report, report_next;
  logic [ROW_W-1:0] crow, crow_next;
  logic [COL_W-1:0] ccol, ccol_next;

  logic             emit;
  logic             r_ign;
  logic [15:0]      r_cell;
  logic [ROW_W-1:0] w_row;
  logic [COL_W-1:0] w_col;
  logic [ADDR_W-1:0] idx;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_ahead;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign init_busy = state[3] && !report;
  assign cnt_m1    = cnt - CNT_W'(1);
  assign cnt_ahead = cnt + COLS_C;
  assign w_row     = (head.kind == K_WRITE_CUR) ? crow : head.row;
  assign w_col     = (head.kind == K_WRITE_CUR) ? ccol : head.col;
  assign idx       = ADDR_W'(w_row) * COLS_A + ADDR_W'(w_col);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    fill_attr_next = fill_attr;
    report_next    = report;
    crow_next      = crow;
    ccol_next      = ccol;
    we             = 1'b0;
    waddr          = cnt_m1[ADDR_W-1:0];
    wdata          = {fill_attr, 8'h00};
    raddr          = idx;
    pop            = 1'b0;
    emit           = 1'b0;
    r_ign          = 1'b0;
    r_cell         = 16'h0000;
    unique case (state)
      S_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          unique case (head.kind)
            K_WRITE, K_WRITE_CUR: begin
              we    = 1'b1;
              waddr = idx;
              wdata = {head.attr, head.ch};
              if (idx == LAST_A) begin
                crow_next      = ROW_W'(ROWS - 1);
                ccol_next      = '0;
                state_next     = S_SCROLL;
                cnt_next       = '0;
                fill_attr_next = blank_attr;
              end else begin
                emit = 1'b1;
                if (w_col == COL_W'(COLUMNS - 1)) begin
                  crow_next = w_row + ROW_W'(1);
                  ccol_next = '0;
                end else begin
                  crow_next = w_row;
                  ccol_next = w_col + COL_W'(1);
                end
              end
            end
            K_NEWLINE, K_FORMFEED: begin
              if (head.kind == K_NEWLINE) ccol_next = '0;
              if (crow == ROW_W'(ROWS - 1)) begin
                state_next     = S_SCROLL;
                cnt_next       = '0;
                fill_attr_next = blank_attr;
              end else begin
                crow_next = crow + ROW_W'(1);
                emit      = 1'b1;
              end
            end
            K_RETURN: begin
              ccol_next = '0;
              emit      = 1'b1;
            end
            K_CLEAR: begin
              crow_next      = '0;
              ccol_next      = '0;
              state_next     = S_FILL;
              cnt_next       = '0;
              fill_attr_next = blank_attr;
              report_next    = 1'b1;
            end
            K_READ: state_next = S_READ;
            K_IGNORE: begin
              emit  = 1'b1;
              r_ign = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        emit       = 1'b1;
        r_cell     = rdata;
        state_next = S_IDLE;
      end
      S_SCROLL: begin
        raddr = cnt_ahead[ADDR_W-1:0];
        if (cnt != '0) begin
          we    = 1'b1;
          wdata = (cnt_m1 < MOVE_C) ? rdata : {fill_attr, 8'h00};
        end
        if (cnt == CNT_W'(CELLS)) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_FILL: begin
        we    = 1'b1;
        waddr = cnt[ADDR_W-1:0];
        if (cnt == CNT_W'(CELLS - 1)) begin
          emit       = report;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      cnt       <= '0;
      fill_attr <= RESET_BLANK_ATTR;
      report    <= 1'b0;
      crow      <= '0;
      ccol      <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      fill_attr <= fill_attr_next;
      report    <= report_next;
      crow      <= crow_next;
      ccol      <= ccol_next;
      done      <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cursor_row <= crow_next;
      cursor_col <= ccol_next;
      cell_char  <= r_cell[7:0];
      cell_attr  <= r_cell[15:8];
      ignored    <= r_ign;
    end
  end

endmodule

// ===== src/text_console_writer.sv =====
// Text console writer: top level joining front end, queue and back end.
// Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back and the defines header.
// After reset all ROWS*COLUMNS (2000) cells are blanked; busy is high then. Print, control
// characters, ignored positions: queue slot, then result register; 1/cycle unless a scroll,
// clear or read holds the back end. Read: registered memory read. Scroll, clear: all cells.
// A two-word queue lets up to two commands be taken while the back end works.
`include "text_console_writer_defines.svh"
module text_console_writer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                cmd,
  input  logic [7:0]                char_code,
  input  logic [3:0]                ink_color,
  input  logic [3:0]                paper_color,
  input  logic [tcw_pkg::ROW_W-1:0] row,
  input  logic [tcw_pkg::COL_W-1:0] col,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [7:0]                cfg_data,
  output logic                      done,
  output logic [tcw_pkg::ROW_W-1:0] cursor_row,
  output logic [tcw_pkg::COL_W-1:0] cursor_col,
  output logic [7:0]                cell_char,
  output logic [7:0]                cell_attr,
  output logic                      ignored
);
  import tcw_pkg::*;

  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  logic       init_busy;
  op_t        push_op;
  op_t        head;
  logic [7:0] blank_attr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) blank_attr <= RESET_BLANK_ATTR;
    else if (cfg_valid && cfg_ready) blank_attr <= cfg_data;
  end

  tcw_front u_front (
    .start(start), .q_full(q_full), .init_busy(init_busy), .cmd(cmd),
    .char_code(char_code), .ink_color(ink_color), .paper_color(paper_color),
    .row(row), .col(col), .busy(busy), .push(push), .op(push_op)
  );

  tcw_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_op(push_op), .pop(pop),
    .full(q_full), .empty(q_empty), .head(head)
  );

  tcw_back u_back (
    .clk(clk), .rst(rst), .empty(q_empty), .head(head), .blank_attr(blank_attr),
    .pop(pop), .init_busy(init_busy), .done(done), .cursor_row(cursor_row),
    .cursor_col(cursor_col), .cell_char(cell_char), .cell_attr(cell_attr),
    .ignored(ignored)
  );

  `TCW_ASSERT_IMP(a_cursor_on_screen, done,
    (cursor_row < ROW_W'(ROWS)) && (cursor_col < COL_W'(COLUMNS)))
  `TCW_ASSERT_IMP(a_ignored_zero, done && ignored,
    (cell_char == 8'h00) && (cell_attr == 8'h00))
  `TCW_ASSERT_NEXT(a_no_push_when_full, q_full && !pop, !push)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for text_console_writer: drives console commands and blank
// attribute writes, predicts cursor, cell reads and ignore flags from its own cell model.
// Depends on tcw_pkg and the text_console_writer RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int LIMIT = 15000000;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] ch;
    logic [3:0] fg;
    logic [3:0] bg;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
  } cmd_word_t;

  typedef struct {
    logic [ROW_W-1:0] crow;
    logic [COL_W-1:0] ccol;
    logic [7:0] rch;
    logic [7:0] rattr;
    logic ign;
  } status_t;

  logic clk = 1'b0, rst = 1'b1;
  logic start = 1'b0, busy;
  logic [1:0] cmd = '0;
  logic [7:0] char_code = '0;
  logic [3:0] ink_color = '0, paper_color = '0;
  logic [ROW_W-1:0] row = '0;
  logic [COL_W-1:0] col = '0;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [7:0] cfg_data = '0;
  logic done;
  logic [ROW_W-1:0] cursor_row;
  logic [COL_W-1:0] cursor_col;
  logic [7:0] cell_char, cell_attr;
  logic ignored;

  text_console_writer dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .char_code(char_code),
    .ink_color(ink_color), .paper_color(paper_color), .row(row), .col(col),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data), .done(done),
    .cursor_row(cursor_row), .cursor_col(cursor_col), .cell_char(cell_char),
    .cell_attr(cell_attr), .ignored(ignored)
  );

  initial forever #10 clk = ~clk;

  // console model
  logic [15:0] screen [CELLS];
  int cur_idx;
  logic [7:0] blank_attr;

  cmd_word_t pend_q[$];
  status_t status_q[$];
  int n_acc = 0, n_seen = 0;
  int errors = 0;
  int cycles = 0;
  bit no_gaps = 0;
  int gap = 0;

  function automatic void blank_all();
    for (int i = 0; i < CELLS; i++) screen[i] = {blank_attr, 8'h00};
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i + COLUMNS < CELLS; i++) screen[i] = screen[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {blank_attr, 8'h00};
  endfunction

  function automatic void feed_line();
    if (cur_idx / COLUMNS == ROWS - 1) scroll_screen();
    else cur_idx += COLUMNS;
  endfunction

  function automatic void put_glyph(logic [7:0] ch, logic [7:0] attr, int r, int c);
    int idx;
    if (ch == CH_NEWLINE) begin
      feed_line();
      cur_idx -= cur_idx % COLUMNS;
    end else if (ch == CH_FORMFEED) begin
      feed_line();
    end else if (ch == CH_RETURN) begin
      cur_idx -= cur_idx % COLUMNS;
    end else begin
      idx = r * COLUMNS + c;
      screen[idx] = {attr, ch};
      if (idx == CELLS - 1) begin
        scroll_screen();
        cur_idx = (ROWS - 1) * COLUMNS;
      end else begin
        cur_idx = idx + 1;
      end
    end
  endfunction

  function automatic status_t console_step(cmd_word_t w);
    status_t s;
    bit on_screen;
    logic [7:0] attr;
    attr = {w.bg, w.fg};
    on_screen = (w.r < ROWS) && (w.c < COLUMNS);
    s.rch = '0;
    s.rattr = '0;
    s.ign = 1'b0;
    case (w.cmd)
      CMD_PRINT: put_glyph(w.ch, attr, cur_idx / COLUMNS, cur_idx % COLUMNS);
      CMD_PRINT_AT: begin
        if (on_screen) put_glyph(w.ch, attr, int'(w.r), int'(w.c));
        else s.ign = 1'b1;
      end
      CMD_CLEAR: begin
        blank_all();
        cur_idx = 0;
      end
      default: begin
        if (on_screen) {s.rattr, s.rch} = screen[w.r * COLUMNS + w.c];
        else s.ign = 1'b1;
      end
    endcase
    s.crow = ROW_W'(cur_idx / COLUMNS);
    s.ccol = COL_W'(cur_idx % COLUMNS);
    return s;
  endfunction

  function automatic cmd_word_t mk(logic [1:0] cm, logic [7:0] ch, int fg,
                                   int bg, int r, int c);
    cmd_word_t w;
    w.cmd = cm; w.ch = ch; w.fg = 4'(fg); w.bg = 4'(bg); w.r = ROW_W'(r); w.c = COL_W'(c);
    return w;
  endfunction

  function automatic logic [7:0] rand_char();
    int k;
    k = $urandom_range(0, 99);
    if (k < 4) return CH_NEWLINE;
    if (k < 7) return CH_FORMFEED;
    if (k < 11) return CH_RETURN;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic cmd_word_t rand_word();
    cmd_word_t w;
    int k;
    k = $urandom_range(0, 99);
    w.fg = 4'($urandom_range(0, 15));
    w.bg = 4'($urandom_range(0, 15));
    w.ch = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 6) == 0) begin
      w.r = ROW_W'($urandom_range(0, 31));
      w.c = COL_W'($urandom_range(0, 127));
    end else begin
      w.r = ROW_W'($urandom_range(0, ROWS - 1));
      w.c = COL_W'($urandom_range(0, COLUMNS - 1));
    end
    if (k < 45) begin
      w.cmd = CMD_PRINT;
      w.ch = rand_char();
    end else if (k < 65) begin
      w.cmd = CMD_PRINT_AT;
      if ($urandom_range(0, 99) < 15) w.ch = rand_char();
      if ($urandom_range(0, 19) == 0) begin
        w.r = ROW_W'(ROWS - 1);
        w.c = COL_W'(COLUMNS - 1);
      end
    end else if (k < 67) begin
      w.cmd = CMD_CLEAR;
    end else begin
      w.cmd = CMD_READ;
    end
    return w;
  endfunction

  function automatic int pick_gap();
    int k;
    if (no_gaps) return 0;
    k = $urandom_range(0, 99);
    if (k < 70) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  always @(negedge clk) begin
    cmd_word_t w;
    if (!rst && !(start && n_acc == n_seen)) begin
      if (start) n_seen <= n_acc;
      if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (pend_q.size() > 0) begin
        w = pend_q.pop_front();
        cmd <= w.cmd; char_code <= w.ch; ink_color <= w.fg; paper_color <= w.bg;
        row <= w.r; col <= w.c;
        start <= 1'b1;
        gap <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // acceptance, prediction and result check
  always @(posedge clk) begin
    status_t e;
    cmd_word_t w;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst) begin
      if (start && !busy) begin
        w.cmd = cmd; w.ch = char_code; w.fg = ink_color; w.bg = paper_color;
        w.r = row; w.c = col;
        status_q.push_back(console_step(w));
        n_acc <= n_acc + 1;
      end
      if (done) begin
        if (status_q.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = status_q.pop_front();
          if (cursor_row !== e.crow) begin
            $error("cursor_row expected %0d actual %0d", e.crow, cursor_row); errors++;
          end
          if (cursor_col !== e.ccol) begin
            $error("cursor_col expected %0d actual %0d", e.ccol, cursor_col); errors++;
          end
          if (cell_char !== e.rch) begin
            $error("cell_char expected %0h actual %0h", e.rch, cell_char); errors++;
          end
          if (cell_attr !== e.rattr) begin
            $error("cell_attr expected %0h actual %0h", e.rattr, cell_attr); errors++;
          end
          if (ignored !== e.ign) begin
            $error("ignored expected %0d actual %0d", e.ign, ignored); errors++;
          end
        end
      end
    end
  end

  task automatic write_blank(logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    blank_attr = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (pend_q.size() != 0 || start || status_q.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    logic [7:0] attrs [4];
    blank_attr = RESET_BLANK_ATTR;
    blank_all();
    cur_idx = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words on reset blank attribute
    pend_q.push_back(mk(CMD_READ, 8'h00, 0, 0, 0, 0));
    pend_q.push_back(mk(CMD_PRINT, 8'h00, 0, 0, 0, 0));
    pend_q.push_back(mk(CMD_PRINT, 8'hFF, 15, 15, 0, 0));
    pend_q.push_back(mk(CMD_PRINT, CH_FORMFEED, 1, 2, 0, 0));
    pend_q.push_back(mk(CMD_PRINT, CH_RETURN, 1, 2, 0, 0));
    pend_q.push_back(mk(CMD_PRINT, CH_NEWLINE, 1, 2, 0, 0));
    pend_q.push_back(mk(CMD_READ, 8'h00, 0, 0, 0, 1));
    pend_q.push_back(mk(CMD_PRINT_AT, 8'h41, 15, 0, ROWS, 0));
    pend_q.push_back(mk(CMD_PRINT_AT, 8'h41, 0, 15, 0, COLUMNS));
    pend_q.push_back(mk(CMD_PRINT_AT, 8'h41, 15, 15, 31, 127));
    pend_q.push_back(mk(CMD_PRINT_AT, CH_NEWLINE, 3, 4, 10, 10));
    pend_q.push_back(mk(CMD_PRINT_AT, 8'h5A, 9, 6, 10, 40));
    pend_q.push_back(mk(CMD_READ, 8'h00, 0, 0, 10, 40));
    pend_q.push_back(mk(CMD_READ, 8'h00, 0, 0, 31, 127));
    pend_q.push_back(mk(CMD_PRINT_AT, 8'h7E, 15, 15, ROWS - 1, COLUMNS - 1));
    pend_q.push_back(mk(CMD_READ, 8'h00, 0, 0, ROWS - 2, COLUMNS - 1));
    pend_q.push_back(mk(CMD_READ, 8'h00, 0, 0, ROWS - 1, COLUMNS - 1));
    pend_q.push_back(mk(CMD_PRINT, CH_FORMFEED, 0, 0, 0, 0));
    pend_q.push_back(mk(CMD_PRINT, CH_NEWLINE, 0, 0, 0, 0));
    pend_q.push_back(mk(CMD_PRINT_AT, CH_RETURN, 0, 0, 0, 0));
    pend_q.push_back(mk(CMD_CLEAR, 8'h00, 0, 0, 0, 0));
    pend_q.push_back(mk(CMD_READ, 8'h00, 0, 0, ROWS - 1, COLUMNS - 1));
    drain();

    attrs[0] = 8'hFF;
    attrs[1] = 8'h00;
    attrs[2] = 8'($urandom_range(0, 255));
    attrs[3] = 8'($urandom_range(0, 255));
    for (int p = 0; p < 4; p++) begin
      write_blank(attrs[p]);
      no_gaps = (p == 1);
      pend_q.push_back(mk(CMD_CLEAR, 8'h00, 0, 0, 0, 0));
      pend_q.push_back(mk(CMD_READ, 8'h00, 0, 0, 0, 0));
      for (int i = 0; i < 455; i++) pend_q.push_back(rand_word());
      drain();
    end

    repeat (CELLS + 20) @(posedge clk);
    if (errors == 0 && status_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== text_console_writer.f =====
+incdir+src
src/tcw_pkg.sv
src/tcw_front.sv
src/tcw_queue.sv
src/tcw_back.sv
src/text_console_writer.sv
tb/testbench.sv
